// ===== hw/rtl/utf32_to_utf8_utf16_transcoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// utf32_to_utf8_utf16_transcoder_unit assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef UTF32_TO_UTF8_UTF16_TRANSCODER_UNIT_DEFINES_SVH
`define UTF32_TO_UTF8_UTF16_TRANSCODER_UNIT_DEFINES_SVH

// assertion that is switched off while reset is held
`define U2U_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is also checked while reset is held
`define U2U_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg
// types, register indexes and encoding constants of the utf-32 transcoder
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_IN_LE  = 2'd0;
    localparam logic [1:0] REG_FORMAT = 2'd1;
    localparam logic [1:0] REG_SWAP   = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [31:0] CP_MAX     = 32'h0010_ffff;
    localparam logic [20:0] SURR_TAG   = 21'h00001b;
    localparam logic [20:0] REPL_CP    = 21'h00fffd;
    localparam logic [20:0] PLANE1     = 21'h010000;
    localparam logic [20:0] TWO_BYTE   = 21'h000800;
    localparam logic [20:0] ONE_BYTE   = 21'h000080;
    localparam logic [15:0] HI_SURR    = 16'hd800;
    localparam logic [15:0] LO_SURR    = 16'hdc00;
    localparam logic [7:0]  LEAD4      = 8'hf0;
    localparam logic [7:0]  LEAD3      = 8'he0;
    localparam logic [7:0]  LEAD2      = 8'hc0;
    localparam logic [7:0]  CONT       = 8'h80;

    typedef logic [15:0] unit_t;

    typedef struct packed {
        logic in_le;
        logic format;
        logic swap;
    } cfg_t;

    typedef struct packed {
        unit_t [3:0] units;
        logic [2:0]  count;
    } enc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u2u_if.sv =====
// ----------------------------------------------------------------------------
// u2u channel interfaces
// valid/ready channels for code words and for output units
// ----------------------------------------------------------------------------
`default_nettype none

interface u2u_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_word;

    modport source (output valid, output code_word, input ready);
    modport sink   (input valid, input code_word, output ready);
endinterface

interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit;
    logic        last_unit;

    modport source (output valid, output unit, output last_unit, input ready);
    modport sink   (input valid, input unit, input last_unit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u2u_encode.sv =====
// ----------------------------------------------------------------------------
// u2u_encode
// turns one code word into up to four utf-8 bytes or two utf-16 units
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_encode
    import u2u_pkg::*;
(
    input  logic [31:0] code_word,
    input  cfg_t        cfg,
    output enc_t        enc
);

    logic [31:0] raw;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] ofs;
    logic        dst_le;

    always_comb
    begin
        raw    = cfg.in_le ? {code_word[7:0], code_word[15:8],
                              code_word[23:16], code_word[31:24]} : code_word;
        bad    = (raw > CP_MAX) || (raw[31:11] == SURR_TAG);
        cp     = bad ? REPL_CP : raw[20:0];
        ofs    = cp - PLANE1;
        dst_le = cfg.in_le ^ cfg.swap;
        enc    = '0;
        if (!cfg.format)
        begin
            if (cp == '0)
            begin
                enc.count = 3'd0;
            end
            else if (cp >= PLANE1)
            begin
                enc.units[0] = {8'h00, LEAD4 | {5'd0, cp[20:18]}};
                enc.units[1] = {8'h00, CONT | {2'd0, cp[17:12]}};
                enc.units[2] = {8'h00, CONT | {2'd0, cp[11:6]}};
                enc.units[3] = {8'h00, CONT | {2'd0, cp[5:0]}};
                enc.count    = 3'd4;
            end
            else if (cp >= TWO_BYTE)
            begin
                enc.units[0] = {8'h00, LEAD3 | {4'd0, cp[15:12]}};
                enc.units[1] = {8'h00, CONT | {2'd0, cp[11:6]}};
                enc.units[2] = {8'h00, CONT | {2'd0, cp[5:0]}};
                enc.count    = 3'd3;
            end
            else if (cp >= ONE_BYTE)
            begin
                enc.units[0] = {8'h00, LEAD2 | {3'd0, cp[10:6]}};
                enc.units[1] = {8'h00, CONT | {2'd0, cp[5:0]}};
                enc.count    = 3'd2;
            end
            else
            begin
                enc.units[0] = {9'd0, cp[6:0]};
                enc.count    = 3'd1;
            end
        end
        else
        begin
            if (cp >= PLANE1)
            begin
                enc.units[0] = HI_SURR + {6'd0, ofs[19:10]};
                enc.units[1] = LO_SURR + {6'd0, ofs[9:0]};
                enc.count    = 3'd2;
            end
            else
            begin
                enc.units[0] = cp[15:0];
                enc.count    = 3'd1;
            end
            if (dst_le)
            begin
                enc.units[0] = {enc.units[0][7:0], enc.units[0][15:8]};
                enc.units[1] = {enc.units[1][7:0], enc.units[1][15:8]};
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf32_to_utf8_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf32_to_utf8_utf16_transcoder_unit
// utf-32 code words in, utf-8 bytes or utf-16 units out, apb register port
// ----------------------------------------------------------------------------
//  channel   dir   payload                    transfer
//  code_ch   in    code_word[31:0]            valid & ready
//  unit_ch   out   unit[15:0], last_unit      valid & ready
//  apb       in    3 one-bit registers        psel & penable & pwrite
//
//  one result unit per cycle while unit_ch is not stalled: an item gives up
//  to 4 units, set by the unit serializer feeding the one-unit output register
//  a code word goes through the input word, serializer and output registers
//  a utf-8 zero word is consumed and gives no unit
//  rst_n clears the valid bits, config and unit count, no clearing pass
//  a stalled output holds its unit while the input stage keeps one word
// ----------------------------------------------------------------------------
`default_nettype none

module utf32_to_utf8_utf16_transcoder_unit
    import u2u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    u2u_word_if.sink          code_ch,
    u2u_unit_if.source        unit_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        wr;

    logic        w_valid_reg;
    logic        w_valid_next;
    logic [31:0] w_reg;
    logic [31:0] w_next;

    enc_t        enc;

    unit_t [3:0] b_units_reg;
    unit_t [3:0] b_units_next;
    logic [2:0]  b_cnt_reg;
    logic [2:0]  b_cnt_next;
    logic [1:0]  b_idx_reg;
    logic [1:0]  b_idx_next;

    logic        o_valid_reg;
    logic        o_valid_next;
    unit_t       o_unit_reg;
    unit_t       o_unit_next;
    logic        o_last_reg;
    logic        o_last_next;

    logic        out_free;
    logic        b_busy;
    logic        emit;
    logic        b_load;
    logic        w_free;

    // register port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (paddr[3:2])
                REG_IN_LE:  cfg_next.in_le  = pwdata[0];
                REG_FORMAT: cfg_next.format = pwdata[0];
                REG_SWAP:   cfg_next.swap   = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IN_LE:  prdata = {{(APB_DW-1){1'b0}}, cfg_reg.in_le};
            REG_FORMAT: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.format};
            REG_SWAP:   prdata = {{(APB_DW-1){1'b0}}, cfg_reg.swap};
            default:    prdata = '0;
        endcase
    end

    u2u_encode u_encode (
        .code_word (w_reg),
        .cfg       (cfg_reg),
        .enc       (enc)
    );

    // handshake and serializer control
    always_comb
    begin
        out_free = !o_valid_reg || unit_ch.ready;
        b_busy   = (b_cnt_reg != 3'd0);
        emit     = b_busy && out_free;
        b_load   = w_valid_reg && (!b_busy || (emit && (b_cnt_reg == 3'd1)));
        w_free   = !w_valid_reg || b_load;

        w_valid_next = w_valid_reg;
        w_next       = w_reg;
        if (w_free)
        begin
            w_valid_next = code_ch.valid;
            w_next       = code_ch.code_word;
        end

        b_units_next = b_units_reg;
        b_cnt_next   = b_cnt_reg;
        b_idx_next   = b_idx_reg;
        if (emit)
        begin
            b_cnt_next = b_cnt_reg - 3'd1;
            b_idx_next = b_idx_reg + 2'd1;
        end
        if (b_load)
        begin
            b_units_next = enc.units;
            b_cnt_next   = enc.count;
            b_idx_next   = 2'd0;
        end

        o_valid_next = o_valid_reg;
        o_unit_next  = o_unit_reg;
        o_last_next  = o_last_reg;
        if (out_free)
        begin
            o_valid_next = emit;
            o_unit_next  = b_units_reg[b_idx_reg];
            o_last_next  = (b_cnt_reg == 3'd1);
        end
    end

    assign code_ch.ready     = w_free;
    assign unit_ch.valid     = o_valid_reg;
    assign unit_ch.unit      = o_unit_reg;
    assign unit_ch.last_unit = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            w_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
            b_idx_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            w_valid_reg <= w_valid_next;
            b_cnt_reg   <= b_cnt_next;
            b_idx_reg   <= b_idx_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        b_units_reg <= b_units_next;
        o_unit_reg  <= o_unit_next;
        o_last_reg  <= o_last_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u2u_checker.sv =====
// ----------------------------------------------------------------------------
// u2u_checker
// port-level assertions for the transcoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf32_to_utf8_utf16_transcoder_unit_defines.svh"

module u2u_checker
    import u2u_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              unit_valid,
    input wire logic              unit_ready,
    input wire logic [15:0]       unit,
    input wire logic              last_unit,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [APB_AW-1:0] paddr,
    input wire logic [APB_DW-1:0] pwdata,
    input wire logic [APB_DW-1:0] prdata,
    input wire logic              pready
);

    logic reg_wr;

    assign reg_wr = psel && penable && pwrite && pready && (paddr[3:2] != REG_UNUSED);

    property p_stall_holds;
        unit_valid && !unit_ready |=> unit_valid && $stable(unit) && $stable(last_unit);
    endproperty

    property p_readback;
        reg_wr ##1 $stable(paddr) |-> prdata[APB_DW-1:1] == '0 && prdata[0] == $past(pwdata[0]);
    endproperty

    property p_hole_reads_zero;
        psel && (paddr[3:2] == REG_UNUSED) |-> prdata == '0 && pready;
    endproperty

    `U2U_ASSERT_ALWAYS(a_no_unit_in_reset, clk, !rst_n |-> !unit_valid, "unit valid in reset")

    `U2U_ASSERT_RUN(a_stall_holds, clk, rst_n, p_stall_holds, "stalled unit changed")

    `U2U_ASSERT_RUN(a_readback, clk, rst_n, p_readback, "register readback mismatch")

    `U2U_ASSERT_RUN(a_hole_reads_zero, clk, rst_n, p_hole_reads_zero, "unmapped register not zero")

endmodule

bind utf32_to_utf8_utf16_transcoder_unit u2u_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .unit_valid (unit_ch.valid),
    .unit_ready (unit_ch.ready),
    .unit       (unit_ch.unit),
    .last_unit  (unit_ch.last_unit),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

`default_nettype wire
